// ===== hdl/lcdcmd_pkg.sv =====
// Shared types, codes and constant tables for the character display command generator.
// Used by lcdcmd_front, lcdcmd_queue, lcdcmd_back and char_lcd_cursor_command_gen.
package lcdcmd_pkg;

    localparam int LINE_CHARS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Event opcodes
    localparam logic [1:0] OP_PUT_CHAR = 2'd0;
    localparam logic [1:0] OP_GOTO     = 2'd1;
    localparam logic [1:0] OP_MOVE     = 2'd2;
    localparam logic [1:0] OP_INIT     = 2'd3;

    // Move directions
    localparam logic [1:0] DIR_LEFT   = 2'd0;
    localparam logic [1:0] DIR_RIGHT  = 2'd1;
    localparam logic [1:0] DIR_TOGGLE = 2'd2;

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN  = 8'd13;

    localparam logic [7:0] CMD_SET_POS  = 8'h80;
    localparam logic [7:0] COL_MASK     = 8'h0F;
    localparam logic [7:0] CMD_ROW1_COL0 = 8'hC0;

    // Register select codes
    localparam logic RS_INSTR = 1'b0;
    localparam logic RS_DATA  = 1'b1;

    // Init sequence: four single nibbles, then five instruction bytes
    localparam int         STEP_W      = 4;
    localparam logic [STEP_W-1:0] INIT_LAST_STEP   = 4'd8;
    localparam logic [STEP_W-1:0] INIT_NIBBLE_STEPS = 4'd4;

    typedef enum logic [1:0] {
        KIND_SINGLE = 2'd0,
        KIND_PAIR   = 2'd1,
        KIND_INIT   = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic       rs;
        logic [7:0] value;
    } t_cmd;

    typedef struct packed {
        logic [7:0] col;
        logic       row;
    } t_cursor;

    function automatic logic [7:0] set_pos_cmd(input logic row, input logic [7:0] col);
        set_pos_cmd = CMD_SET_POS | {1'b0, row, 6'b0} | (col & COL_MASK);
    endfunction

    function automatic logic [7:0] init_byte(input logic [STEP_W-1:0] step);
        case (step)
            4'd0:    init_byte = 8'h03;
            4'd1:    init_byte = 8'h03;
            4'd2:    init_byte = 8'h03;
            4'd3:    init_byte = 8'h02;
            4'd4:    init_byte = 8'h28;
            4'd5:    init_byte = 8'h08;
            4'd6:    init_byte = 8'h01;
            4'd7:    init_byte = 8'h06;
            4'd8:    init_byte = 8'h0F;
            default: init_byte = 8'h00;
        endcase
    endfunction

endpackage

// ===== hdl/lcdcmd_front.sv =====
// Front end: accepts events, keeps the cursor and turns each event into at most one queued command.
// Depends on lcdcmd_pkg.
module lcdcmd_front #(
    parameter int LINE_CHARS = lcdcmd_pkg::LINE_CHARS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [1:0]           i_opcode,
    input  logic [7:0]           i_char_code,
    input  logic [3:0]           i_target_col,
    input  logic                 i_target_row,
    input  logic [1:0]           i_move_dir,
    output logic                 o_push,
    output lcdcmd_pkg::t_cmd     o_cmd,
    output lcdcmd_pkg::t_cursor  o_cursor
);
    import lcdcmd_pkg::*;

    localparam int RECIP_SHIFT = 12;
    localparam int RECIP       = ((2 ** RECIP_SHIFT) + LINE_CHARS - 1) / LINE_CHARS;

    logic [7:0]  r_col, n_col;
    logic        r_row, n_row;
    logic [7:0]  col_inc;
    logic [7:0]  col_dec;
    logic [7:0]  step_col;
    logic [7:0]  mag;
    logic [17:0] prod;
    logic [5:0]  quot;
    logic [13:0] quot_l;
    logic [7:0]  rem_full;
    logic [7:0]  moved_col;
    logic        push;
    t_cmd        cmd;

    assign col_inc = r_col + 8'd1;
    assign col_dec = r_col - 8'd1;

    // Truncated remainder of the signed column, sign dropped: |s| mod LINE_CHARS.
    // The quotient comes from a reciprocal multiply, exact for magnitudes up to 128.
    assign step_col  = (i_move_dir == DIR_LEFT) ? col_dec : col_inc;
    assign mag       = step_col[7] ? (~step_col + 8'd1) : step_col;
    assign prod      = {10'd0, mag} * {8'd0, 10'(RECIP)};
    assign quot      = prod[17:RECIP_SHIFT];
    assign quot_l    = {8'd0, quot} * {6'd0, 8'(LINE_CHARS)};
    assign rem_full  = mag - quot_l[7:0];
    assign moved_col = {4'd0, rem_full[3:0]};

    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        push       = 1'b0;
        cmd.kind   = KIND_SINGLE;
        cmd.rs     = RS_INSTR;
        cmd.value  = 8'd0;
        case (i_opcode)
            OP_PUT_CHAR: begin
                push = 1'b1;
                if (i_char_code == CH_NEWLINE) begin
                    n_col     = 8'd0;
                    n_row     = ~r_row;
                    cmd.value = set_pos_cmd(~r_row, 8'd0);
                end else if (i_char_code == CH_RETURN) begin
                    n_col     = 8'd0;
                    cmd.value = set_pos_cmd(r_row, 8'd0);
                end else if (!col_inc[7] && (col_inc > 8'(LINE_CHARS - 1)) && !r_row) begin
                    // End of the first line: the data write is followed by a jump to row 1.
                    cmd.kind  = KIND_PAIR;
                    cmd.rs    = RS_DATA;
                    cmd.value = i_char_code;
                    n_col     = 8'd0;
                    n_row     = 1'b1;
                end else begin
                    cmd.rs    = RS_DATA;
                    cmd.value = i_char_code;
                    n_col     = col_inc;
                end
            end
            OP_GOTO: begin
                push      = 1'b1;
                n_col     = {4'd0, i_target_col};
                n_row     = i_target_row;
                cmd.value = set_pos_cmd(i_target_row, {4'd0, i_target_col});
            end
            OP_MOVE: begin
                case (i_move_dir)
                    DIR_LEFT, DIR_RIGHT: begin
                        push      = 1'b1;
                        n_col     = moved_col;
                        cmd.value = set_pos_cmd(r_row, moved_col);
                    end
                    DIR_TOGGLE: begin
                        push      = 1'b1;
                        n_row     = ~r_row;
                        cmd.value = set_pos_cmd(~r_row, r_col);
                    end
                    default: begin
                        push = 1'b0;
                    end
                endcase
            end
            default: begin
                push     = 1'b1;
                cmd.kind = KIND_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= 8'd0;
            r_row <= 1'b0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_push       = i_accept && push;
    assign o_cmd        = cmd;
    assign o_cursor.col = r_col;
    assign o_cursor.row = r_row;

endmodule

// ===== hdl/lcdcmd_queue.sv =====
// Small first-in first-out queue of commands between the front and back ends.
// Depends on lcdcmd_pkg.
module lcdcmd_queue #(
    parameter int DEPTH = lcdcmd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lcdcmd_pkg::t_cmd i_cmd,
    input  logic             i_pop,
    output lcdcmd_pkg::t_cmd o_head,
    output logic             o_full,
    output logic             o_empty
);
    import lcdcmd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/lcdcmd_back.sv =====
// Back end: expands queued commands into output register writes, one per cycle unless stalled.
// Depends on lcdcmd_pkg.
module lcdcmd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lcdcmd_pkg::t_cmd i_head,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [7:0]       o_m_tdata,
    output logic [1:0]       o_m_tuser,
    output logic             o_m_tlast
);
    import lcdcmd_pkg::*;

    logic              r_valid;
    logic [7:0]        r_data;
    logic              r_rs;
    logic              r_nib;
    logic              r_last;
    logic [STEP_W-1:0] r_step;
    logic              load;
    logic [7:0]        gen_data;
    logic              gen_rs;
    logic              gen_nib;
    logic              gen_last;

    assign load = !r_valid || i_m_tready;

    always_comb begin
        gen_data = i_head.value;
        gen_rs   = i_head.rs;
        gen_nib  = 1'b0;
        gen_last = 1'b1;
        case (i_head.kind)
            KIND_SINGLE: begin
                gen_last = 1'b1;
            end
            KIND_PAIR: begin
                if (r_step != '0) begin
                    gen_data = CMD_ROW1_COL0;
                    gen_rs   = RS_INSTR;
                    gen_last = 1'b1;
                end else begin
                    gen_last = 1'b0;
                end
            end
            KIND_INIT: begin
                gen_data = init_byte(r_step);
                gen_rs   = RS_INSTR;
                gen_nib  = (r_step < INIT_NIBBLE_STEPS);
                gen_last = (r_step == INIT_LAST_STEP);
            end
            default: begin
                gen_last = 1'b1;
            end
        endcase
    end

    assign o_pop = load && !i_empty && gen_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (!i_empty) begin
                r_step <= gen_last ? '0 : r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            r_data <= gen_data;
            r_rs   <= gen_rs;
            r_nib  <= gen_nib;
            r_last <= gen_last;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tuser  = {r_nib, r_rs};
    assign o_m_tlast  = r_last;

endmodule

// ===== hdl/char_lcd_cursor_command_gen.sv =====
// Top level of the character display command generator.
// Depends on lcdcmd_pkg, lcdcmd_front, lcdcmd_queue and lcdcmd_back.
//
// Events arrive on the slave stream: tuser carries the opcode, tdata the
// character, target position and move direction. Each event yields zero to
// nine bus writes on the master stream: tdata is the byte (or nibble in the
// low bits), tuser gives register select and the nibble flag, and tlast
// marks the final write of the event.
// An event is taken whenever the command queue has room; its first write
// reaches the master side via the queue and then the back end's single
// output register, which holds one write per transfer and sets the rate
// of one write per cycle while the receiver is ready. So a character takes
// one or two writes, a position or move one, and init nine.
// Reset puts the cursor at row 0, column 0 and empties queue and output.
// When the receiver stalls, the output write holds and the queue fills;
// events keep being accepted until it is full (QUEUE_DEPTH commands).
module char_lcd_cursor_command_gen #(
    parameter int LINE_CHARS  = lcdcmd_pkg::LINE_CHARS_DEF,
    parameter int QUEUE_DEPTH = lcdcmd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // char_code[7:0], target_col[11:8], target_row[12],
                                     // move_dir[14:13], zero[15]
    input  logic [1:0]  i_s_tuser,   // opcode[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // bus_value[7:0]
    output logic [1:0]  o_m_tuser,   // reg_select[0], nibble_only[1]
    output logic        o_m_tlast
);
    import lcdcmd_pkg::*;

    logic    s_accept;
    logic    push;
    t_cmd    front_cmd;
    t_cmd    head;
    t_cursor cursor;
    logic    q_full;
    logic    q_empty;
    logic    pop;

    assign o_s_tready = !q_full;
    assign s_accept   = i_s_tvalid && o_s_tready;

    lcdcmd_front #(
        .LINE_CHARS (LINE_CHARS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (s_accept),
        .i_opcode     (i_s_tuser),
        .i_char_code  (i_s_tdata[7:0]),
        .i_target_col (i_s_tdata[11:8]),
        .i_target_row (i_s_tdata[12]),
        .i_move_dir   (i_s_tdata[14:13]),
        .o_push       (push),
        .o_cmd        (front_cmd),
        .o_cursor     (cursor)
    );

    lcdcmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    lcdcmd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_empty    (q_empty),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // A carriage return leaves the cursor at column 0 of the same row.
    a_cr_homes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_s_tuser == OP_PUT_CHAR && i_s_tdata[7:0] == CH_RETURN)
        |=> (cursor.col == 8'd0 && cursor.row == $past(cursor.row)))
        else $error("carriage return did not home the cursor");

    // Init nibbles are never the final write of an event.
    a_nibble_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> !o_m_tlast)
        else $error("nibble write marked as last");

    // A nibble write carries only the low four bits and goes to the instruction register.
    a_nibble_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> (o_m_tdata[7:4] == 4'd0 && o_m_tuser[0] == RS_INSTR))
        else $error("malformed nibble write");

endmodule
